/* hdl/vn_pkg.sv */
// vn_pkg: shared types and constants for the vector3_normalizer pipeline.
// No dependencies.
package vn_pkg;
   localparam int CompWidth  = 32;              // component and length width
   localparam int SumWidth   = 64;              // sum of squares, Q32.32
   localparam int SqrtSteps  = 32;              // one result bit per stage
   localparam int FracBits   = 30;              // Q2.30 fraction bits
   localparam int QuotWidth  = FracBits + 1;    // quotient in [0, 2^30]
   localparam int RemWidth   = CompWidth + 1;   // partial remainder, below 2*len

   // Per-item side data carried alongside the square root pipeline.
   typedef struct packed {
      logic [2:0][CompWidth-1:0] mag;
      logic [2:0]                neg;
      logic                      zero;
   } side_type;
endpackage

/* hdl/vector3_normalizer.sv */
// vector3_normalizer: top level of the 3D vector normalizer pipeline.
// Depends on vn_pkg, vn_square, vn_sqrt, vn_div.
//
// Usage:
//   req_ channel: one beat carries a vector (req_in_x/y/z, signed Q16.16).
//   rsp_ channel: one beat per request, in order: unit vector in signed
//     Q2.30 (rsp_unit_x/y/z), length in unsigned Q16.16 (rsp_length,
//     truncated square root of the sum of squares) and rsp_zero_error.
//   A zero vector returns zero_error = 1 with all other fields zero.
// Throughput: one beat per cycle, sustained, whenever rsp_ready is high.
// Pipeline: 67 register stages: 3 stages magnitude / square / sum,
//   32 stages of square root (one root bit each), 31 stages of division
//   (one quotient bit each, three lanes), 1 output register.
// Stall: the whole pipeline advances on one enable. When the output
//   register holds an untaken beat and rsp_ready is low, every stage
//   freezes and req_ready drops; nothing is lost or repeated. Bubbles in
//   the pipeline are not squeezed out; they advance with the beats.
// Reset: synchronous, active high; clears all stage valid bits and holds
//   req_ready low. The block keeps no state between beats.
module vector3_normalizer import vn_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [CompWidth-1:0] req_in_x,
   input  logic signed [CompWidth-1:0] req_in_y,
   input  logic signed [CompWidth-1:0] req_in_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [CompWidth-1:0] rsp_unit_x,
   output logic signed [CompWidth-1:0] rsp_unit_y,
   output logic signed [CompWidth-1:0] rsp_unit_z,
   output logic [CompWidth-1:0]        rsp_length,
   output logic                        rsp_zero_error
);
   logic                     adv;
   logic                     sq_valid, rt_valid, dv_valid;
   logic [SumWidth-1:0]      sq_sum;
   side_type                 sq_side, rt_side;
   logic [CompWidth-1:0]     rt_root, dv_len;
   logic                     dv_zero;
   logic signed [2:0][CompWidth-1:0] dv_unit;

   logic                     rsp_valid_ff, rsp_zero_ff;
   logic [2:0][CompWidth-1:0] rsp_unit_ff;
   logic [CompWidth-1:0]     rsp_len_ff;

   // Advance everything unless a finished beat waits at the output.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !reset;

   vn_square u_square (
      .clock, .reset, .adv,
      .in_valid  (req_valid),
      .in_x      (req_in_x),
      .in_y      (req_in_y),
      .in_z      (req_in_z),
      .out_valid (sq_valid),
      .out_sum   (sq_sum),
      .out_side  (sq_side)
   );

   vn_sqrt u_sqrt (
      .clock, .reset, .adv,
      .in_valid  (sq_valid),
      .in_sum    (sq_sum),
      .in_side   (sq_side),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   vn_div u_div (
      .clock, .reset, .adv,
      .in_valid  (rt_valid),
      .in_len    (rt_root),
      .in_side   (rt_side),
      .out_valid (dv_valid),
      .out_len   (dv_len),
      .out_zero  (dv_zero),
      .out_unit  (dv_unit)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
      if (adv) begin
         rsp_unit_ff <= dv_unit;
         rsp_len_ff  <= dv_len;
         rsp_zero_ff <= dv_zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_unit_x     = rsp_unit_ff[0];
   assign rsp_unit_y     = rsp_unit_ff[1];
   assign rsp_unit_z     = rsp_unit_ff[2];
   assign rsp_length     = rsp_len_ff;
   assign rsp_zero_error = rsp_zero_ff;

   // Zero vector gives all-zero fields.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_error |->
         rsp_length == '0 && rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0)
      else $error("zero vector beat with nonzero fields");

   // Nonzero vector has nonzero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_error |-> rsp_length != '0)
      else $error("nonzero vector with zero length");

   // Unit components stay within [-1.0, 1.0].
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_unit_x <= 32'sd1073741824 && rsp_unit_x >= -32'sd1073741824 &&
         rsp_unit_y <= 32'sd1073741824 && rsp_unit_y >= -32'sd1073741824 &&
         rsp_unit_z <= 32'sd1073741824 && rsp_unit_z >= -32'sd1073741824)
      else $error("unit component out of range");
endmodule

/* hdl/vn_square.sv */
// vn_square: magnitude, square and sum of squares, three register stages.
// Depends on vn_pkg.
module vn_square import vn_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic signed [CompWidth-1:0] in_x,
   input  logic signed [CompWidth-1:0] in_y,
   input  logic signed [CompWidth-1:0] in_z,
   output logic                        out_valid,
   output logic [SumWidth-1:0]         out_sum,
   output side_type                    out_side
);
   logic [2:0]                     valid_ff;
   logic [2:0][CompWidth-1:0]      comp_in;
   side_type                       side_a_ff, side_b_ff, side_c_ff, side_a_in;
   logic [2:0][SumWidth-1:0]       sq_ff;
   logic [SumWidth-1:0]            sum_ff;

   assign comp_in = {in_z, in_y, in_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         side_a_in.neg[i] = comp_in[i][CompWidth-1];
         side_a_in.mag[i] = comp_in[i][CompWidth-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
      end
      side_a_in.zero = (comp_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
      if (adv) begin
         side_a_ff <= side_a_in;
         side_b_ff <= side_a_ff;
         side_c_ff <= side_b_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SumWidth'(side_a_ff.mag[i]) * SumWidth'(side_a_ff.mag[i]);
         end
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_sum   = sum_ff;
   assign out_side  = side_c_ff;
endmodule

/* hdl/vn_sqrt.sv */
// vn_sqrt: pipelined digit-by-digit integer square root, one bit per stage.
// Depends on vn_pkg.
module vn_sqrt import vn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [SumWidth-1:0]  in_sum,
   input  side_type             in_side,
   output logic                 out_valid,
   output logic [CompWidth-1:0] out_root,
   output side_type             out_side
);
   logic [SqrtSteps:0]               valid_s;
   logic [SqrtSteps:0][SumWidth-1:0] rem_s, root_s;
   side_type [SqrtSteps:0]           side_s;

   assign valid_s[0] = in_valid;
   assign rem_s[0]   = in_sum;
   assign root_s[0]  = '0;
   assign side_s[0]  = in_side;

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
      localparam logic [SumWidth-1:0] Bit = SumWidth'(1) << (SumWidth - 2 - 2*k);
      logic [SumWidth-1:0] trial, rem_in, root_in;
      logic                valid_ff;
      logic [SumWidth-1:0] rem_ff, root_ff;
      side_type            side_ff;

      always_comb begin
         trial = root_s[k] + Bit;
         if (rem_s[k] >= trial) begin
            rem_in  = rem_s[k] - trial;
            root_in = (root_s[k] >> 1) + Bit;
         end else begin
            rem_in  = rem_s[k];
            root_in = root_s[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_s[k];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_s[k];
         end
      end

      assign valid_s[k+1] = valid_ff;
      assign rem_s[k+1]   = rem_ff;
      assign root_s[k+1]  = root_ff;
      assign side_s[k+1]  = side_ff;
   end

   assign out_valid = valid_s[SqrtSteps];
   assign out_root  = root_s[SqrtSteps][CompWidth-1:0];
   assign out_side  = side_s[SqrtSteps];
endmodule

/* hdl/vn_div.sv */
// vn_div: three-lane pipelined restoring divider, (mag << 30) / len.
// Depends on vn_pkg. Relies on mag <= len, so the quotient is at most 2^30.
module vn_div import vn_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [CompWidth-1:0]        in_len,
   input  side_type                    in_side,
   output logic                        out_valid,
   output logic [CompWidth-1:0]        out_len,
   output logic                        out_zero,
   output logic signed [2:0][CompWidth-1:0] out_unit
);
   logic [FracBits:0]                          valid_s;
   logic [FracBits:0][CompWidth-1:0]           len_s;
   logic [FracBits:0][2:0][RemWidth-1:0]       rem_s;
   logic [FracBits:0][2:0][QuotWidth-1:0]      quot_s;
   logic [FracBits:0][2:0]                     neg_s;
   logic [FracBits:0]                          zero_s;

   // First stage: top quotient bit, set only when mag equals len.
   logic                           valid0_ff, zero0_ff;
   logic [CompWidth-1:0]           len0_ff;
   logic [2:0][RemWidth-1:0]       rem0_ff;
   logic [2:0][QuotWidth-1:0]      quot0_ff;
   logic [2:0]                     neg0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (adv) begin
         valid0_ff <= in_valid;
      end
      if (adv) begin
         len0_ff  <= in_len;
         neg0_ff  <= in_side.neg;
         zero0_ff <= in_side.zero;
         for (int i = 0; i < 3; i++) begin
            if (in_side.mag[i] >= in_len) begin
               rem0_ff[i]  <= RemWidth'(in_side.mag[i] - in_len);
               quot0_ff[i] <= QuotWidth'(1) << FracBits;
            end else begin
               rem0_ff[i]  <= RemWidth'(in_side.mag[i]);
               quot0_ff[i] <= '0;
            end
         end
      end
   end

   assign valid_s[0] = valid0_ff;
   assign len_s[0]   = len0_ff;
   assign rem_s[0]   = rem0_ff;
   assign quot_s[0]  = quot0_ff;
   assign neg_s[0]   = neg0_ff;
   assign zero_s[0]  = zero0_ff;

   for (genvar k = 0; k < FracBits; k++) begin : g_step
      localparam int QBit = FracBits - 1 - k;
      logic [2:0][RemWidth-1:0]  rem_in, rem_ff;
      logic [2:0][QuotWidth-1:0] quot_in, quot_ff;
      logic [RemWidth-1:0]       dbl;
      logic                      valid_ff, zero_ff;
      logic [CompWidth-1:0]      len_ff;
      logic [2:0]                neg_ff;

      always_comb begin
         dbl = '0;
         for (int i = 0; i < 3; i++) begin
            dbl        = {rem_s[k][i][RemWidth-2:0], 1'b0};
            quot_in[i] = quot_s[k][i];
            if (dbl >= RemWidth'(len_s[k])) begin
               rem_in[i]        = dbl - RemWidth'(len_s[k]);
               quot_in[i][QBit] = 1'b1;
            end else begin
               rem_in[i] = dbl;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= valid_s[k];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            len_ff  <= len_s[k];
            neg_ff  <= neg_s[k];
            zero_ff <= zero_s[k];
         end
      end

      assign valid_s[k+1] = valid_ff;
      assign rem_s[k+1]   = rem_ff;
      assign quot_s[k+1]  = quot_ff;
      assign len_s[k+1]   = len_ff;
      assign neg_s[k+1]   = neg_ff;
      assign zero_s[k+1]  = zero_ff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (zero_s[FracBits]) begin
            out_unit[i] = '0;
         end else if (neg_s[FracBits][i]) begin
            out_unit[i] = -CompWidth'(quot_s[FracBits][i]);
         end else begin
            out_unit[i] = CompWidth'(quot_s[FracBits][i]);
         end
      end
   end

   assign out_valid = valid_s[FracBits];
   assign out_len   = len_s[FracBits];
   assign out_zero  = zero_s[FracBits];
endmodule
